// File: hdl/rgbse_pkg.sv
`default_nettype none
package rgbse_pkg;

    // image size limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // raster counter widths
    localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // register field widths
    localparam int MODE_W  = 1;
    localparam int RWID_W  = 11;
    localparam int BOUND_W = 10;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 3;

    // common compare width for counters against register fields
    localparam int CMP_W = (COL_W + 1 > RWID_W) ? COL_W + 1 : RWID_W;

    // arithmetic widths
    localparam int CH_W   = 8;
    localparam int DIST_W = 18;
    localparam int ACC_W  = 39;

    typedef enum logic [IDX_W-1:0] {
        CFG_MODE      = 3'd0,
        CFG_ROW_WIDTH = 3'd1,
        CFG_X_MIN     = 3'd2,
        CFG_X_MAX     = 3'd3,
        CFG_Y_MIN     = 3'd4,
        CFG_Y_MAX     = 3'd5
    } t_cfg_idx;

    localparam logic [MODE_W-1:0] MODE_FULL  = 1'b0;
    localparam logic [MODE_W-1:0] MODE_DELTA = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

endpackage
`default_nettype wire

// File: hdl/rgbse_dist.sv
`default_nettype none
// squared rgb distance between two pixels
module rgbse_dist (
    input  var rgbse_pkg::t_pixel              i_a,
    input  var rgbse_pkg::t_pixel              i_b,
    output logic [rgbse_pkg::DIST_W-1:0]       o_dist
);
    logic signed [rgbse_pkg::CH_W:0]       dr, dg, db;
    logic signed [2*rgbse_pkg::CH_W+1:0]   sr, sg, sb;

    always_comb begin
        dr = $signed({1'b0, i_a.red})   - $signed({1'b0, i_b.red});
        dg = $signed({1'b0, i_a.green}) - $signed({1'b0, i_b.green});
        db = $signed({1'b0, i_a.blue})  - $signed({1'b0, i_b.blue});
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
    end

    // squares are non-negative and fit in 16 bits each
    assign o_dist = rgbse_pkg::DIST_W'(unsigned'(sr[2*rgbse_pkg::CH_W-1:0]))
                  + rgbse_pkg::DIST_W'(unsigned'(sg[2*rgbse_pkg::CH_W-1:0]))
                  + rgbse_pkg::DIST_W'(unsigned'(sb[2*rgbse_pkg::CH_W-1:0]));

endmodule
`default_nettype wire

// File: hdl/rgb_squared_error_accumulator.sv
`default_nettype none
// channel   direction  handshake           payload
// pixel     in         i_valid / o_stall   target, best, cand rgb, last_pixel
// result    out        o_valid / i_stall   error_total (39 bit signed)
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// one pixel word per cycle sustained while o_stall is low; a pixel is registered
// at accept, then its distances and the accumulate go from that register into
// the accumulator, and for a last pixel the total goes into the result register.
// synchronous active-low reset clears counters, accumulator and valids;
// registers return to full-image mode with a 1024 by 1024 window.
// a stalled result only blocks the pipeline when a second last pixel arrives.
module rgb_squared_error_accumulator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [rgbse_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [rgbse_pkg::CFG_W-1:0]         i_cfg_data,
    // pixel input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [rgbse_pkg::CH_W-1:0]          i_target_red,
    input  logic [rgbse_pkg::CH_W-1:0]          i_target_green,
    input  logic [rgbse_pkg::CH_W-1:0]          i_target_blue,
    input  logic [rgbse_pkg::CH_W-1:0]          i_best_red,
    input  logic [rgbse_pkg::CH_W-1:0]          i_best_green,
    input  logic [rgbse_pkg::CH_W-1:0]          i_best_blue,
    input  logic [rgbse_pkg::CH_W-1:0]          i_cand_red,
    input  logic [rgbse_pkg::CH_W-1:0]          i_cand_green,
    input  logic [rgbse_pkg::CH_W-1:0]          i_cand_blue,
    input  logic                                i_last_pixel,
    // result output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [rgbse_pkg::ACC_W-1:0]  o_error_total
);
    localparam int COL_W   = rgbse_pkg::COL_W;
    localparam int ROW_W   = rgbse_pkg::ROW_W;
    localparam int CMP_W   = rgbse_pkg::CMP_W;
    localparam int ACC_W   = rgbse_pkg::ACC_W;
    localparam int DIST_W  = rgbse_pkg::DIST_W;
    localparam int BOUND_W = rgbse_pkg::BOUND_W;

    // configuration registers
    logic [rgbse_pkg::MODE_W-1:0] r_mode;
    logic [rgbse_pkg::RWID_W-1:0] r_row_width;
    logic [BOUND_W-1:0]           r_x_min, r_x_max, r_y_min, r_y_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= rgbse_pkg::MODE_FULL;
            r_row_width <= rgbse_pkg::RWID_W'(1024);
            r_x_min     <= '0;
            r_x_max     <= '1;
            r_y_min     <= '0;
            r_y_max     <= '1;
        end else if (i_cfg_we) begin
            unique case (rgbse_pkg::t_cfg_idx'(i_cfg_idx))
                rgbse_pkg::CFG_MODE:      r_mode      <= i_cfg_data[rgbse_pkg::MODE_W-1:0];
                rgbse_pkg::CFG_ROW_WIDTH: r_row_width <= i_cfg_data[rgbse_pkg::RWID_W-1:0];
                rgbse_pkg::CFG_X_MIN:     r_x_min     <= i_cfg_data[BOUND_W-1:0];
                rgbse_pkg::CFG_X_MAX:     r_x_max     <= i_cfg_data[BOUND_W-1:0];
                rgbse_pkg::CFG_Y_MIN:     r_y_min     <= i_cfg_data[BOUND_W-1:0];
                rgbse_pkg::CFG_Y_MAX:     r_y_max     <= i_cfg_data[BOUND_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // pipeline control
    logic r_s1_vld, r_s1_last, r_s1_en, r_s1_sub;
    logic r_out_vld;
    logic out_free, s1_adv, accept;

    assign out_free = !r_out_vld || !i_stall;
    // only a last pixel needs the result register
    assign s1_adv   = r_s1_vld && (!r_s1_last || out_free);
    assign o_stall  = r_s1_vld && !s1_adv;
    assign accept   = i_valid && !o_stall;

    // raster counters and window test at accept time
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CMP_W-1:0] col_x, next_col_x;
    logic [ROW_W:0]   next_row_x;
    logic             in_win;

    always_comb begin
        col_x      = CMP_W'(r_col);
        next_col_x = col_x + CMP_W'(1);
        next_row_x = {1'b0, r_row} + (ROW_W+1)'(1);
        in_win = (col_x >= CMP_W'(r_x_min)) && (col_x <= CMP_W'(r_x_max))
              && (CMP_W'(r_row) >= CMP_W'(r_y_min)) && (CMP_W'(r_row) <= CMP_W'(r_y_max));
        n_col = r_col;
        n_row = r_row;
        if (i_last_pixel) begin
            n_col = '0;
            n_row = '0;
        end else if (next_col_x >= CMP_W'(r_row_width)
                     || next_col_x >= CMP_W'(rgbse_pkg::MAX_WIDTH)) begin
            n_col = '0;
            // row wraps after the height limit
            if (next_row_x >= (ROW_W+1)'(rgbse_pkg::MAX_HEIGHT)) begin
                n_row = '0;
            end else begin
                n_row = next_row_x[ROW_W-1:0];
            end
        end else begin
            n_col = next_col_x[COL_W-1:0];
        end
    end

    // input register
    rgbse_pkg::t_pixel r_tgt, r_best, r_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
            r_col    <= n_col;
            r_row    <= n_row;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tgt     <= '{i_target_red, i_target_green, i_target_blue};
            r_best    <= '{i_best_red, i_best_green, i_best_blue};
            r_cand    <= '{i_cand_red, i_cand_green, i_cand_blue};
            r_s1_last <= i_last_pixel;
            r_s1_en   <= (r_mode == rgbse_pkg::MODE_FULL) || in_win;
            r_s1_sub  <= (r_mode == rgbse_pkg::MODE_DELTA);
        end
    end

    // distances and signed delta
    logic [DIST_W-1:0]       cand_dist, best_dist;
    logic signed [ACC_W-1:0] delta, acc_sum;
    logic signed [ACC_W-1:0] r_acc;

    rgbse_dist u_dist_cand (
        .i_a    (r_tgt),
        .i_b    (r_cand),
        .o_dist (cand_dist)
    );

    rgbse_dist u_dist_best (
        .i_a    (r_tgt),
        .i_b    (r_best),
        .o_dist (best_dist)
    );

    always_comb begin
        if (!r_s1_en) begin
            delta = '0;
        end else if (r_s1_sub) begin
            delta = $signed(ACC_W'(cand_dist)) - $signed(ACC_W'(best_dist));
        end else begin
            delta = $signed(ACC_W'(cand_dist));
        end
        acc_sum = r_acc + delta;  // wraps modulo 2^39
    end

    // accumulator and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_acc <= r_s1_last ? '0 : acc_sum;
            end
            if (s1_adv && r_s1_last) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            o_error_total <= acc_sum;
        end
    end

    assign o_valid = r_out_vld;

endmodule
`default_nettype wire
